FILE: src/tki_pkg.sv
// types and constants shared by the top-k insertion block
// no dependencies
package tki_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] score;
		logic        [31:0] tag;
		logic        [2:0]  read_rank;
	} tki_cmd_t;

	typedef struct packed {
		logic               accepted;
		logic        [2:0]  landed_slot;
		logic signed [31:0] read_score;
		logic        [31:0] read_tag;
	} tki_result_t;

	// head of the command queue as seen by the back end
	typedef struct packed {
		logic     valid;
		tki_cmd_t cmd;
	} tki_queue_t;

endpackage

FILE: src/top_k_insert_with_tag.sv
// top level of the top-k score keeper with tags
// depends on tki_pkg, tki_front, tki_back

// Keeps the DEPTH largest signed scores offered, each with its tag, sorted
// ascending (slot 0 smallest). A command is taken when start is high and busy
// is low; its result shows on result for one cycle with done high, after the
// queue and result registers; it cannot be held off. The back end handles
// one command per cycle, since every slot of the table compares against the
// new score at once and shifts in the same cycle, so commands may be issued
// every cycle and busy stays low in steady use. The table resets to the
// minimum score with tag 0.
module top_k_insert_with_tag import tki_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  tki_cmd_t    cmd,
	output logic        done,
	output tki_result_t result
);

	tki_queue_t head;
	logic       pop;

	tki_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.pop    (pop),
		.head   (head)
	);

	tki_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

`ifndef NO_ASSERTIONS
	a_done_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(head.valid))
		else $error("result without a queued transaction");

	a_taken_queued: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> head.valid)
		else $error("accepted transaction missing from queue");

	a_insert_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.accepted |-> result.read_score == 0 && result.read_tag == 0)
		else $error("insert result carries read data");
`endif

endmodule

FILE: src/tki_front.sv
// front end: takes commands and holds them in a two-entry queue
// depends on tki_pkg
module tki_front import tki_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  tki_cmd_t   cmd,
	input  logic       pop,
	output tki_queue_t head
);

	tki_cmd_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign busy = (count_q == 2'd2);
	assign push = start && !busy;

	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/tki_back.sv
// back end: sorted score table as a row of compare-and-shift cells
// depends on tki_pkg
module tki_back import tki_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tki_queue_t  head,
	output logic        pop,
	output logic        done,
	output tki_result_t result
);

	localparam int IW = $clog2(DEPTH);
	localparam int RW = (IW > 3) ? IW : 3;

	logic signed [31:0] score_q [DEPTH];
	logic        [31:0] tag_q   [DEPTH];
	logic signed [31:0] score_nxt [DEPTH];
	logic        [31:0] tag_nxt   [DEPTH];
	logic [DEPTH-1:0]   lt;
	logic               take;
	logic [RW-1:0]      pos;
	logic [RW-1:0]      rank_ext;
	logic               rank_ok;
	tki_result_t        res_nxt;
	logic               done_q;
	tki_result_t        result_q;

	assign pop = head.valid;

	// lt is a thermometer since the table stays sorted
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			lt[i] = score_q[i] < head.cmd.score;
		end
		take = head.valid && (head.cmd.operation == OP_INSERT) && lt[0];

		pos = '0;
		for (int i = 1; i < DEPTH; i++) begin
			if (lt[i] && ((i == DEPTH - 1) || !lt[(i + 1) % DEPTH])) begin
				pos = pos | RW'(i);
			end
		end

		// each cell takes its upper neighbor, the new entry, or holds
		for (int i = 0; i < DEPTH; i++) begin
			score_nxt[i] = score_q[i];
			tag_nxt[i]   = tag_q[i];
			if ((i < DEPTH - 1) && lt[(i + 1) % DEPTH]) begin
				score_nxt[i] = score_q[(i + 1) % DEPTH];
				tag_nxt[i]   = tag_q[(i + 1) % DEPTH];
			end else if (lt[i]) begin
				score_nxt[i] = head.cmd.score;
				tag_nxt[i]   = head.cmd.tag;
			end
		end

		rank_ext = RW'(head.cmd.read_rank);
		rank_ok  = ({1'b0, rank_ext} < (RW + 1)'(DEPTH));

		res_nxt = '0;
		if (head.cmd.operation == OP_INSERT) begin
			if (lt[0]) begin
				res_nxt.accepted    = 1'b1;
				res_nxt.landed_slot = pos[2:0];
			end
		end else if (rank_ok) begin
			res_nxt.read_score = score_q[rank_ext[IW-1:0]];
			res_nxt.read_tag   = tag_q[rank_ext[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				score_q[i] <= SCORE_MIN;
				tag_q[i]   <= '0;
			end
		end else if (take) begin
			for (int i = 0; i < DEPTH; i++) begin
				score_q[i] <= score_nxt[i];
				tag_q[i]   <= tag_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= head.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (head.valid) begin
			result_q <= res_nxt;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: verif/tb_top_k_insert_with_tag.sv
// testbench for the top-k score keeper with tags: directed and random commands
// against a behavioral copy of the sorted table; depends on tki_pkg and top_k_insert_with_tag
`timescale 1ns / 1ps

module tb_top_k_insert_with_tag;
	import tki_pkg::*;

	localparam int TB_DEPTH   = 8;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_CMDS = 950;
	localparam logic signed [31:0] SCORE_MAX = 32'sh7fff_ffff;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	tki_cmd_t    cmd = '0;
	logic        done;
	tki_result_t result;

	// behavioral copy of the table, ascending: slot 0 is the smallest kept score
	logic signed [31:0] kept_score [TB_DEPTH];
	logic        [31:0] kept_tag   [TB_DEPTH];

	tki_result_t expected_results [$];
	tki_result_t oldest_expected;
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          burst_left = 4;

	top_k_insert_with_tag #(.DEPTH(TB_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #6 clk = ~clk;

	// applies one command to the table copy and returns the result it should give
	function automatic tki_result_t apply_to_table(input tki_cmd_t c);
		tki_result_t        r;
		int                 pos;
		logic signed [31:0] hold_score;
		logic        [31:0] hold_tag;
		r = '0;
		if (c.operation == OP_INSERT) begin
			if (c.score > kept_score[0]) begin
				kept_score[0] = c.score;
				kept_tag[0] = c.tag;
				pos = 0;
				// bubble up past every strictly smaller score, stop at an equal one
				while (pos < TB_DEPTH - 1 && kept_score[pos] > kept_score[pos + 1]) begin
					hold_score = kept_score[pos];
					hold_tag = kept_tag[pos];
					kept_score[pos] = kept_score[pos + 1];
					kept_tag[pos] = kept_tag[pos + 1];
					kept_score[pos + 1] = hold_score;
					kept_tag[pos + 1] = hold_tag;
					pos++;
				end
				r.accepted = 1'b1;
				r.landed_slot = pos[2:0];
			end
		end else if (int'(c.read_rank) < TB_DEPTH) begin
			r.read_score = kept_score[c.read_rank];
			r.read_tag = kept_tag[c.read_rank];
		end
		return r;
	endfunction

	function automatic tki_cmd_t insert_cmd(input logic signed [31:0] s, input logic [31:0] t);
		tki_cmd_t c;
		c.operation = OP_INSERT;
		c.score = s;
		c.tag = t;
		c.read_rank = 3'($urandom_range(0, 7));
		return c;
	endfunction

	function automatic tki_cmd_t read_cmd(input logic [2:0] rank);
		tki_cmd_t c;
		c.operation = OP_READ;
		c.score = $urandom();
		c.tag = $urandom();
		c.read_rank = rank;
		return c;
	endfunction

	// start stays high across a burst, so it is lowered only when a gap follows
	task automatic send_cmd(input tki_cmd_t c);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy !== 1'b0);
		expected_results.push_back(apply_to_table(c));
		burst_left--;
		if (burst_left <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
	endtask

	task automatic log_mismatch(input string field, input logic [31:0] e, input logic [31:0] a);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s: expected %h actual %h", field, e, a);
	endtask

	task automatic test_reset_contents;
		send_cmd(read_cmd(3'd0));
		send_cmd(read_cmd(3'd3));
		send_cmd(read_cmd(3'd7));
	endtask

	task automatic test_minimum_score;
		// the minimum score never beats slot 0, even on a fresh table
		send_cmd(insert_cmd(SCORE_MIN, 32'hffff_ffff));
	endtask

	task automatic test_sorted_placement;
		send_cmd(insert_cmd(SCORE_MAX, 32'hffff_ffff));
		send_cmd(insert_cmd(32'sd0, 32'h0000_0000));
		send_cmd(insert_cmd(-32'sd1, 32'h0000_0001));
		// equal score stops below the entry already kept
		send_cmd(insert_cmd(32'sd0, 32'h0000_0002));
		for (int i = 0; i < 5; i++)
			send_cmd(insert_cmd(32'sd100, 32'h1000_0000 + i));
	endtask

	task automatic test_rejected_inserts;
		// table is full now: equal to slot 0 and below slot 0 are both refused
		send_cmd(insert_cmd(kept_score[0], 32'haaaa_aaaa));
		send_cmd(insert_cmd(kept_score[0] - 1, 32'h5555_5555));
	endtask

	task automatic test_read_all_ranks;
		for (int r = 0; r < 8; r++)
			send_cmd(read_cmd(3'(r)));
	endtask

	task automatic test_random_traffic;
		tki_cmd_t c;
		int       pick;
		longint   near;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			c.operation = ($urandom_range(0, 99) < 65) ? OP_INSERT : OP_READ;
			c.tag = $urandom();
			c.read_rank = 3'($urandom_range(0, 7));
			pick = $urandom_range(0, 99);
			if (pick < 40)
				c.score = $urandom();
			else if (pick < 65)
				c.score = int'($urandom_range(0, 80)) - 40;
			else if (pick < 69) begin
				case ($urandom_range(0, 3))
					0: c.score = SCORE_MAX;
					1: c.score = SCORE_MIN;
					2: c.score = SCORE_MAX - 1;
					default: c.score = SCORE_MIN + 1;
				endcase
			end else begin
				// close to slot 0 keeps inserts landing and hitting equal scores
				near = longint'(kept_score[0]) + longint'($urandom_range(0, 8)) - 3;
				if (near > longint'(SCORE_MAX))
					near = longint'(SCORE_MAX);
				if (near < longint'(SCORE_MIN))
					near = longint'(SCORE_MIN);
				c.score = near[31:0];
			end
			send_cmd(c);
		end
	endtask

	// results cannot be held off, so every strobe is checked as it comes
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				log_mismatch("unexpected transaction", 32'h0, {31'h0, done});
			end else begin
				oldest_expected = expected_results.pop_front();
				if (result.accepted !== oldest_expected.accepted)
					log_mismatch("accepted", {31'h0, oldest_expected.accepted},
						{31'h0, result.accepted});
				if (result.landed_slot !== oldest_expected.landed_slot)
					log_mismatch("landed_slot", {29'h0, oldest_expected.landed_slot},
						{29'h0, result.landed_slot});
				if (result.read_score !== oldest_expected.read_score)
					log_mismatch("read_score", oldest_expected.read_score, result.read_score);
				if (result.read_tag !== oldest_expected.read_tag)
					log_mismatch("read_tag", oldest_expected.read_tag, result.read_tag);
			end
		end
	end

	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL top_k_insert_with_tag");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < TB_DEPTH; i++) begin
			kept_score[i] = SCORE_MIN;
			kept_tag[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_contents();
		test_minimum_score();
		test_sorted_placement();
		test_rejected_inserts();
		test_read_all_ranks();
		test_random_traffic();
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("PASS top_k_insert_with_tag");
		else
			$display("FAIL top_k_insert_with_tag");
		$finish;
	end

endmodule
